>>> rtl/ubq_pkg.sv
// Shared constants, codes and types for the urgent-bypass queue.
// No dependencies; used by the cell, the top level and the port checker.
package ubq_pkg;

    localparam int QUEUE_DEPTH  = 8;
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int VALUE_W      = 32;
    localparam int PRIO_W       = 8;
    localparam int HELD_W       = 4;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [PRIO_W-1:0] URGENT_RESET = 8'd10;

    // Opcodes of an input transfer
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Register index of the configuration space
    localparam logic REG_URGENT_LEVEL = 1'b0;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic occupied;
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

>>> rtl/ubq_cell.sv
// One queue slot: holds a value and priority, compares against the urgent level,
// and passes match and selected-value chains to the next slot. Uses ubq_pkg.
module ubq_cell (
    input  logic                        clk,
    input  ubq_pkg::cell_ctrl_t         ctrl,
    input  logic [ubq_pkg::PRIO_W-1:0]  urgent_level,
    input  logic [ubq_pkg::VALUE_W-1:0] item_value,
    input  logic [ubq_pkg::PRIO_W-1:0]  item_priority,
    input  logic [ubq_pkg::VALUE_W-1:0] nb_value,
    input  logic [ubq_pkg::PRIO_W-1:0]  nb_priority,
    input  logic                        found_in,
    input  logic [ubq_pkg::VALUE_W-1:0] sel_in,
    output logic [ubq_pkg::VALUE_W-1:0] value,
    output logic [ubq_pkg::PRIO_W-1:0]  priority_q,
    output logic                        found_out,
    output logic [ubq_pkg::VALUE_W-1:0] sel_out
);
    import ubq_pkg::*;

    logic [VALUE_W-1:0] value_reg;
    logic [PRIO_W-1:0]  prio_reg;
    logic               hit;

    // First urgent slot in the chain claims the removal
    assign hit       = ctrl.occupied && (prio_reg == urgent_level) && !found_in;
    assign found_out = found_in || hit;
    assign sel_out   = hit ? value_reg : sel_in;
    assign value     = value_reg;
    assign priority_q = prio_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            value_reg <= item_value;
            prio_reg  <= item_priority;
        end
        else if (ctrl.shift)
        begin
            // advance the neighbor's entry into this slot
            value_reg <= nb_value;
            prio_reg  <= nb_priority;
        end
    end

endmodule

>>> rtl/urgent_bypass_fifo_queue.sv
// Top level of the urgent-bypass queue: slot chain, entry count, output register
// and APB-style configuration register. Uses ubq_pkg and ubq_cell.

// Takes one enqueue or dequeue transfer per cycle and presents its result in the next
// cycle from an output register; a new transfer is taken whenever that register is
// empty or being drained in the same cycle. Entries sit packed in a row of slots,
// oldest first. A dequeue removes the oldest slot whose priority equals urgent_level
// (found by a compare in every slot and a match chain down the row), or the head when
// none matches, and all slots behind it move up one place at the same clock edge.
// The length of that match chain, one step per slot, sets the cycle time.
// urgent_level sits at byte address 0 and resets to 10; write it only while idle.
module urgent_bypass_fifo_queue (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ubq_pkg::PADDR_W-1:0]        paddr,
    input  logic [ubq_pkg::PDATA_W-1:0]        pwdata,
    output logic [ubq_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               opcode,
    input  logic signed [ubq_pkg::VALUE_W-1:0] item_value,
    input  logic [ubq_pkg::PRIO_W-1:0]         item_priority,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic signed [ubq_pkg::VALUE_W-1:0] removed_value,
    output logic                               removed_was_urgent,
    output logic [ubq_pkg::HELD_W-1:0]         entries_held
);
    import ubq_pkg::*;

    logic [PRIO_W-1:0]  urgent_level_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    status_t            status_reg;
    status_t            status_next;
    logic [VALUE_W-1:0] removed_value_reg;
    logic [VALUE_W-1:0] removed_value_next;
    logic               urgent_reg;
    logic               urgent_next;
    logic [HELD_W-1:0]  held_reg;

    logic               accept;
    logic               full;
    logic               empty;
    logic               enq_go;
    logic               deq_go;
    logic               any_urgent;
    logic               cfg_write;

    cell_ctrl_t         ctrl [QUEUE_DEPTH];
    logic [VALUE_W-1:0] cell_value [QUEUE_DEPTH+1];
    logic [PRIO_W-1:0]  cell_prio [QUEUE_DEPTH+1];
    logic               found [QUEUE_DEPTH+1];
    logic [VALUE_W-1:0] sel [QUEUE_DEPTH+1];

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_URGENT_LEVEL);
    assign prdata    = (paddr[2] == REG_URGENT_LEVEL)
                       ? PDATA_W'(urgent_level_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            urgent_level_reg <= URGENT_RESET;
        end
        else if (cfg_write)
        begin
            urgent_level_reg <= pwdata[PRIO_W-1:0];
        end
    end

    // Handshake
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign enq_go   = accept && (opcode == OP_ENQ) && !full;
    assign deq_go   = accept && (opcode == OP_DEQ) && !empty;

    // Slot chain
    assign found[0]                = 1'b0;
    assign sel[0]                  = '0;
    assign cell_value[QUEUE_DEPTH] = '0;
    assign cell_prio[QUEUE_DEPTH]  = '0;
    assign any_urgent              = found[QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        always_comb
        begin
            ctrl[i].occupied = (CNT_W'(i) < count_reg);
            ctrl[i].load     = enq_go && (CNT_W'(i) == count_reg);
            // slots at or behind the removed one close the gap
            ctrl[i].shift    = deq_go && (any_urgent ? found[i+1] : 1'b1);
        end

        ubq_cell u_cell (
            .clk          (clk),
            .ctrl         (ctrl[i]),
            .urgent_level (urgent_level_reg),
            .item_value   (item_value),
            .item_priority(item_priority),
            .nb_value     (cell_value[i+1]),
            .nb_priority  (cell_prio[i+1]),
            .found_in     (found[i]),
            .sel_in       (sel[i]),
            .value        (cell_value[i]),
            .priority_q   (cell_prio[i]),
            .found_out    (found[i+1]),
            .sel_out      (sel[i+1])
        );
    end

    // Result and count
    always_comb
    begin
        count_next         = count_reg;
        status_next        = ST_INSERTED;
        removed_value_next = '0;
        urgent_next        = 1'b0;
        unique case (opcode)
            OP_ENQ:
            begin
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    status_next = ST_INSERTED;
                    count_next  = count_reg + 1'b1;
                end
            end
            OP_DEQ:
            begin
                if (empty)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    status_next        = ST_REMOVED;
                    count_next         = count_reg - 1'b1;
                    removed_value_next = any_urgent ? sel[QUEUE_DEPTH] : cell_value[0];
                    urgent_next        = any_urgent;
                end
            end
            default:
            begin
                status_next = ST_INSERTED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg        <= status_next;
            removed_value_reg <= removed_value_next;
            urgent_reg        <= urgent_next;
            held_reg          <= HELD_W'(count_next);
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign removed_value      = removed_value_reg;
    assign removed_was_urgent = urgent_reg;
    assign entries_held       = held_reg;

endmodule

>>> rtl/ubq_port_checker.sv
// Port-level checks for the urgent-bypass queue, bound to the top level.
// Uses ubq_pkg for status codes and opcodes.
module ubq_port_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               opcode,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [1:0]                         status,
    input  logic signed [ubq_pkg::VALUE_W-1:0] removed_value,
    input  logic                               removed_was_urgent,
    input  logic [ubq_pkg::HELD_W-1:0]         entries_held
);
    import ubq_pkg::*;

    // A held result does not change until its transfer completes
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
                                  && $stable(removed_value) && $stable(entries_held))
        else $error("result changed while stalled");

    // An enqueue transfer yields insert or overflow in the next cycle
    a_enq_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (opcode == OP_ENQ) |=> out_valid
            && (status == ST_INSERTED || status == ST_OVERFLOW))
        else $error("enqueue gave a wrong status");

    // A dequeue transfer yields removal or underflow in the next cycle
    a_deq_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (opcode == OP_DEQ) |=> out_valid
            && (status == ST_REMOVED || status == ST_UNDERFLOW))
        else $error("dequeue gave a wrong status");

    // Only a removal carries a value or the urgent flag; underflow means empty
    a_no_removal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_REMOVED) |-> (removed_value == 0) && !removed_was_urgent)
        else $error("value reported without removal");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_UNDERFLOW) |-> (entries_held == '0))
        else $error("underflow with entries held");

endmodule

bind urgent_bypass_fifo_queue ubq_port_checker u_ubq_port_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .opcode            (opcode),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .removed_value     (removed_value),
    .removed_was_urgent(removed_was_urgent),
    .entries_held      (entries_held)
);
